// ----- design/assert_macros.svh -----
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- design/cpd_pkg.sv -----
// ----------------------------------------------------------------------------
// cpd_pkg
// Shared types, sizes and codes of the counting pocket dictionary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package cpd_pkg;
	localparam int NUM_QUOTIENTS = 32;
	localparam int CAPACITY      = 32;
	localparam int REM_BITS      = 8;
	localparam int CNT_BITS      = 4;
	localparam int Q_W   = 5;
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int QI_W  = $clog2(NUM_QUOTIENTS);
	localparam int QC_W  = $clog2(NUM_QUOTIENTS + 1);

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_INCR   = 2'd2;
	localparam logic [1:0] CMD_REMOVE = 2'd3;

	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_ABSENT = 3'd1;
	localparam logic [2:0] ST_LAST   = 3'd2;
	localparam logic [2:0] ST_SAT    = 3'd3;
	localparam logic [2:0] ST_FULL   = 3'd4;

	localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

	// controller to datapath
	typedef struct packed {
		logic load;      // capture request, clear sums
		logic sum_step;  // add one run length to prefix sum
		logic scan_step; // compare one entry of the run
		logic shift_up;  // move one entry upward
		logic shift_dn;  // move one entry downward
		logic finish;    // apply the update and form the result
	} cpd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic sum_done;
		logic scan_done;
		logic shift_done;
		logic need_up;
		logic need_dn;
	} cpd_stat_t;
endpackage
`default_nettype wire

// ----- design/counting_pocket_dictionary_top.sv -----
// ----------------------------------------------------------------------------
// counting_pocket_dictionary_top
// Counting pocket dictionary bucket with one result per request.
// ----------------------------------------------------------------------------
// One request at a time: an accept step, a prefix sum over the run lengths
// (32 steps and a completion step), a scan that compares one run entry per
// step, a decision, an entry shift on insert or delete that moves one entry per
// step, and a result step, all run by the one-entry-a-cycle sum, scan and shift
// sequencer. The next request is taken while a result waits, but it cannot
// finish until that result is taken.
`timescale 1ns / 1ps
`default_nettype none
module counting_pocket_dictionary_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] cmd,
	input  wire logic [4:0] quotient,
	input  wire logic [7:0] remainder,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [2:0]      status,
	output logic [3:0]      count,
	output logic [5:0]      occupancy
);
	cpd_pkg::cpd_cmd_t  c;
	cpd_pkg::cpd_stat_t s;

	cpd_ctrl u_ctrl (.clk, .arst_n, .in_valid, .in_stall, .out_valid, .out_stall,
		.stat(s), .cmd(c));
	cpd_dp u_dp (.clk, .arst_n, .cmd(c), .stat(s), .cmd_in(cmd), .quotient,
		.remainder, .status, .count, .occupancy);
endmodule
`default_nettype wire

// ----- design/cpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// cpd_ctrl
// Sequencer: prefix sum, run scan, entry shift, result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cpd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire cpd_pkg::cpd_stat_t stat,
	output cpd_pkg::cpd_cmd_t       cmd
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SUM  = 3'd1;
	localparam logic [2:0] S_SCAN = 3'd2;
	localparam logic [2:0] S_DEC  = 3'd3;
	localparam logic [2:0] S_UP   = 3'd4;
	localparam logic [2:0] S_DN   = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic       ovalid_q;
	logic       free;

	// a request may finish once the result slot is free or being taken
	assign free      = !ovalid_q || !out_stall;
	assign in_stall  = !(state_q == S_IDLE);
	assign out_valid = ovalid_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_SUM:  cmd.sum_step = !stat.sum_done;
			S_SCAN: cmd.scan_step = !stat.scan_done;
			S_UP:   cmd.shift_up = !stat.shift_done;
			S_DN:   cmd.shift_dn = !stat.shift_done;
			S_FIN:  cmd.finish = free;
			default: ;
		endcase
	end

	// advance the sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ovalid_q <= 1'b0;
		end else begin
			if (ovalid_q && !out_stall) ovalid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_SUM;
				S_SUM:  if (stat.sum_done) state_q <= S_SCAN;
				S_SCAN: if (stat.scan_done) state_q <= S_DEC;
				S_DEC: begin
					if (stat.need_up) state_q <= S_UP;
					else if (stat.need_dn) state_q <= S_DN;
					else state_q <= S_FIN;
				end
				S_UP:   if (stat.shift_done) state_q <= S_FIN;
				S_DN:   if (stat.shift_done) state_q <= S_FIN;
				S_FIN: begin
					if (free) begin
						ovalid_q <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- design/cpd_dp.sv -----
// ----------------------------------------------------------------------------
// cpd_dp
// Datapath: run lengths, entry store, scan pointer and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module cpd_dp (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire cpd_pkg::cpd_cmd_t            cmd,
	output cpd_pkg::cpd_stat_t                stat,
	input  wire logic [1:0]                   cmd_in,
	input  wire logic [cpd_pkg::Q_W-1:0]      quotient,
	input  wire logic [7:0]                   remainder,
	output logic [2:0]                        status,
	output logic [3:0]                        count,
	output logic [5:0]                        occupancy
);
	localparam int RB = cpd_pkg::REM_BITS;
	localparam int CB = cpd_pkg::CNT_BITS;
	localparam int IW = cpd_pkg::IDX_W;
	localparam int OW = cpd_pkg::OCC_W;

	logic [OW-1:0] run_len_q [cpd_pkg::NUM_QUOTIENTS];
	logic [RB-1:0] rem_q [cpd_pkg::CAPACITY];
	logic [CB-1:0] cnt_q [cpd_pkg::CAPACITY];

	logic [1:0]              op_q;
	logic [cpd_pkg::Q_W-1:0] q_q;
	logic [RB-1:0]           r_q;
	logic                    qok_q;
	logic [cpd_pkg::QC_W-1:0] qi_q;   // quotients summed so far
	logic [OW-1:0]           start_q, occ_q, pos_q, end_q, ptr_q;
	logic                    found_q, stop_q;
	logic [CB-1:0]           hit_cnt_q; // counter of the matching entry
	logic [2:0]              status_q;
	logic [3:0]              count_q;
	logic [5:0]              occ_out_q;

	logic [OW-1:0] run_q_len;
	logic [RB-1:0] r_in;
	logic [IW-1:0] pidx, pidx_m1, pidx_p1;
	logic          full;

	always_comb begin
		r_in = RB'(remainder);
		run_q_len = run_len_q[q_q[cpd_pkg::QI_W-1:0]];
		pidx    = ptr_q[IW-1:0];
		pidx_m1 = IW'(ptr_q - OW'(1));
		pidx_p1 = IW'(ptr_q + OW'(1));
		full    = occ_q >= OW'(cpd_pkg::CAPACITY);
		stat.sum_done   = (qi_q == cpd_pkg::QC_W'(cpd_pkg::NUM_QUOTIENTS));
		stat.scan_done  = stop_q || !qok_q || (ptr_q >= end_q);
		stat.need_up    = qok_q && !found_q && op_q == cpd_pkg::CMD_INSERT && !full;
		stat.need_dn    = qok_q && found_q && op_q == cpd_pkg::CMD_REMOVE
			&& hit_cnt_q <= CB'(1);
		stat.shift_done = (op_q == cpd_pkg::CMD_INSERT) ? (ptr_q <= pos_q)
			: (ptr_q + OW'(1) >= occ_q);
	end

	// update the run length of the quotient when the result is applied
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cpd_pkg::NUM_QUOTIENTS; i++) run_len_q[i] <= '0;
		end else if (cmd.finish && qok_q) begin
			if (stat.need_up)
				run_len_q[q_q[cpd_pkg::QI_W-1:0]] <= run_q_len + OW'(1);
			else if (stat.need_dn)
				run_len_q[q_q[cpd_pkg::QI_W-1:0]] <= run_q_len - OW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= cmd_in;
			q_q     <= quotient;
			r_q     <= r_in;
			qok_q   <= 32'(quotient) < cpd_pkg::NUM_QUOTIENTS;
			qi_q    <= '0;
			start_q <= '0;
			occ_q   <= '0;
			found_q <= 1'b0;
			stop_q  <= 1'b0;
		end
		// accumulate total and run start
		if (cmd.sum_step) begin
			occ_q <= occ_q + run_len_q[qi_q[cpd_pkg::QI_W-1:0]];
			if (qi_q < cpd_pkg::QC_W'(q_q))
				start_q <= start_q + run_len_q[qi_q[cpd_pkg::QI_W-1:0]];
			qi_q <= qi_q + cpd_pkg::QC_W'(1);
		end
		if (cmd.scan_step) begin
			if (rem_q[pidx] == r_q) begin
				found_q <= 1'b1; stop_q <= 1'b1; pos_q <= ptr_q;
				hit_cnt_q <= cnt_q[pidx];
			end else if (rem_q[pidx] > r_q) begin
				stop_q <= 1'b1; pos_q <= ptr_q;
			end else begin
				ptr_q <= ptr_q + OW'(1);
				pos_q <= ptr_q + OW'(1);
			end
		end
		if (cmd.sum_step && qi_q + cpd_pkg::QC_W'(1) == cpd_pkg::QC_W'(cpd_pkg::NUM_QUOTIENTS)) begin
			// sum completes now: ready the scan window
			ptr_q <= (qi_q < cpd_pkg::QC_W'(q_q))
				? start_q + run_len_q[qi_q[cpd_pkg::QI_W-1:0]] : start_q;
			pos_q <= (qi_q < cpd_pkg::QC_W'(q_q))
				? start_q + run_len_q[qi_q[cpd_pkg::QI_W-1:0]] : start_q;
			end_q <= ((qi_q < cpd_pkg::QC_W'(q_q))
				? start_q + run_len_q[qi_q[cpd_pkg::QI_W-1:0]] : start_q) + run_q_len;
		end
		// ready the shift pointer after the scan
		if (!cmd.scan_step && !cmd.shift_up && !cmd.shift_dn && stat.scan_done
			&& !cmd.sum_step && !cmd.load && !cmd.finish && stat.sum_done) begin
			ptr_q <= (op_q == cpd_pkg::CMD_INSERT) ? occ_q : pos_q;
		end
		if (cmd.shift_up) begin
			rem_q[pidx] <= rem_q[pidx_m1];
			cnt_q[pidx] <= cnt_q[pidx_m1];
			ptr_q <= ptr_q - OW'(1);
		end
		if (cmd.shift_dn) begin
			rem_q[pidx] <= rem_q[pidx_p1];
			cnt_q[pidx] <= cnt_q[pidx_p1];
			ptr_q <= ptr_q + OW'(1);
		end
		// apply update and form the result
		if (cmd.finish) begin
			status_q  <= cpd_pkg::ST_ABSENT;
			count_q   <= '0;
			occ_out_q <= 6'(occ_q);
			if (!qok_q) begin
				if (op_q == cpd_pkg::CMD_INSERT) status_q <= cpd_pkg::ST_FULL;
			end else if (op_q == cpd_pkg::CMD_LOOKUP) begin
				if (found_q) begin status_q <= cpd_pkg::ST_OK; count_q <= 4'(hit_cnt_q); end
			end else if (op_q == cpd_pkg::CMD_REMOVE) begin
				if (found_q && hit_cnt_q > CB'(1)) begin
					cnt_q[pos_q[IW-1:0]] <= hit_cnt_q - CB'(1);
					status_q <= cpd_pkg::ST_OK; count_q <= 4'(hit_cnt_q - CB'(1));
				end else if (found_q) begin
					status_q <= cpd_pkg::ST_LAST;
					occ_out_q <= 6'(occ_q - OW'(1));
				end
			end else if (found_q) begin
				if (hit_cnt_q >= cpd_pkg::CNT_MAX) begin
					status_q <= cpd_pkg::ST_SAT; count_q <= 4'(hit_cnt_q);
				end else begin
					cnt_q[pos_q[IW-1:0]] <= hit_cnt_q + CB'(1);
					status_q <= cpd_pkg::ST_OK; count_q <= 4'(hit_cnt_q + CB'(1));
				end
			end else if (op_q == cpd_pkg::CMD_INSERT) begin
				if (full) status_q <= cpd_pkg::ST_FULL;
				else begin
					rem_q[pos_q[IW-1:0]] <= r_q;
					cnt_q[pos_q[IW-1:0]] <= CB'(1);
					count_q <= 4'd1;
					occ_out_q <= 6'(occ_q + OW'(1));
				end
			end
		end
	end

	assign status    = status_q;
	assign count     = count_q;
	assign occupancy = occ_out_q;
endmodule
`default_nettype wire

// ----- design/cpd_checker.sv -----
// ----------------------------------------------------------------------------
// cpd_checker
// Port-level checks of the counting pocket dictionary.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cpd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [2:0] status,
	input wire logic [3:0] count,
	input wire logic [5:0] occupancy
);
	logic zero_cnt_case;

	// last copy removed and refused inserts carry no count
	assign zero_cnt_case = out_valid
		&& (status == cpd_pkg::ST_LAST || status == cpd_pkg::ST_FULL);

	`ASSERT_IMPL(a_occ_range, clk, arst_n, out_valid, occupancy <= 6'(cpd_pkg::CAPACITY), "occupancy too big")
	`ASSERT_IMPL(a_st_range, clk, arst_n, out_valid, status <= cpd_pkg::ST_FULL, "bad status")
	`ASSERT_IMPL(a_zero_cnt, clk, arst_n, zero_cnt_case, count == 4'd0, "count not zero")
	`ASSERT_NEXT(a_busy, clk, arst_n, in_valid && !in_stall, in_stall, "accepted twice")
endmodule
bind counting_pocket_dictionary_top cpd_checker u_chk (.*);
`default_nettype wire
